[src/ptm_pkg.sv]
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants, codes and types for the particle topology matcher.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int MAX_TOPOLOGIES = 16;
  localparam int NUM_TYPES      = 16;
  localparam int MAX_PARTICLES  = 31;

  localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int TOPO_W = (MAX_TOPOLOGIES > 1) ? $clog2(MAX_TOPOLOGIES) : 1;
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int ADDR_W = TOPO_W + TYPE_W;

  localparam logic [1:0] MODE_TOPO  = 2'd0;
  localparam logic [1:0] MODE_EXACT = 2'd1;
  localparam logic [1:0] MODE_INCL  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TYPE_W-1:0] type_idx_t;
  typedef logic [TOPO_W-1:0] topo_idx_t;

  typedef struct packed {
    logic add;
    logic in_range;
    logic clr;
  } buf_ctl_t;

  function automatic logic type_in_range(input logic [3:0] code);
    type_in_range = (int'(code) < NUM_TYPES);
  endfunction

endpackage

[src/ptm_count_buf.sv]
// ----------------------------------------------------------------------------
// ptm_count_buf
// Per-type particle count buffer with saturating size and drop flag.
// ----------------------------------------------------------------------------
module ptm_count_buf (
  input  logic               clk,
  input  logic               rst,
  input  ptm_pkg::buf_ctl_t  ctl,
  input  ptm_pkg::type_idx_t addr,
  output ptm_pkg::cnt_t      rd_data,
  output ptm_pkg::cnt_t      size,
  output logic               ovf
);

  ptm_pkg::cnt_t counts [ptm_pkg::NUM_TYPES];
  logic          full;

  assign full    = (int'(size) >= ptm_pkg::MAX_PARTICLES);
  assign rd_data = counts[addr];

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      for (int k = 0; k < ptm_pkg::NUM_TYPES; k++) begin
        counts[k] <= '0;
      end
      size <= '0;
      ovf  <= 1'b0;
    end else if (ctl.add) begin
      if (!ctl.in_range || full) begin
        ovf <= 1'b1;
      end else begin
        counts[addr] <= counts[addr] + ptm_pkg::cnt_t'(1);
        size         <= size + ptm_pkg::cnt_t'(1);
      end
    end
  end

endmodule

[src/particle_topology_matcher.sv]
// ----------------------------------------------------------------------------
// particle_topology_matcher
// Stores topologies as per-type counts and matches events against them.
// ----------------------------------------------------------------------------
// One input word is taken on a clock edge with start high and busy low.
// Mode 0 adds a particle to the topology being built, modes 1 and 2 add a
// particle to the current event; mode 3 is ignored.
// After a word without last, busy stays low.
// A word with last raises busy and gives one result, marked by done for
// a single cycle; the receiver cannot stall it.
//   Topology stored: the row is copied into the table one type per cycle,
//     then the answer step raises done.
//   Table full, or no topologies stored: the answer step follows directly.
//   Event match: the table is read one count per cycle through a single
//     compare unit, then a drain step and the answer step follow.
// Busy drops in the cycle done is shown, so a new word may be taken then.
// Reset empties the table and both count buffers; table rows above the
// stored total are never read, so the table itself is not cleared.
// ----------------------------------------------------------------------------
module particle_topology_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode,
  input  logic [3:0] type_code,
  input  logic       last,
  input  logic       restrict_extra,
  input  logic [3:0] extra_type,
  output logic       done,
  output logic       kind,
  output logic       found,
  output logic [3:0] topo_index,
  output logic [4:0] particle_count,
  output logic [1:0] error
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_COPY   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_ANSWER = 3'd4;

  localparam ptm_pkg::type_idx_t T_LAST = ptm_pkg::TYPE_W'(ptm_pkg::NUM_TYPES - 1);

  logic [2:0]                state;
  logic [ptm_pkg::TOPO_W:0]  total;
  ptm_pkg::topo_idx_t        row;
  ptm_pkg::type_idx_t        col;
  logic                      kind_q;
  logic                      full_q;
  logic                      found_q;
  ptm_pkg::topo_idx_t        idx_q;
  logic [1:0]                mode_q;
  logic                      restrict_q;
  logic [3:0]                extra_q;

  logic                      p_valid;
  ptm_pkg::topo_idx_t        p_row;
  ptm_pkg::type_idx_t        p_col;
  ptm_pkg::cnt_t             p_ev;
  logic                      row_ok;
  logic                      row_ok_next;
  logic                      step_ok;

  ptm_pkg::cnt_t             mem [2**ptm_pkg::ADDR_W];
  ptm_pkg::cnt_t             tp_rd;
  logic                      mem_we;

  logic                      accept;
  logic                      is_event;
  ptm_pkg::type_idx_t        buf_addr;
  ptm_pkg::buf_ctl_t         bld_ctl;
  ptm_pkg::buf_ctl_t         ev_ctl;
  ptm_pkg::cnt_t             bld_rd;
  ptm_pkg::cnt_t             bld_size;
  logic                      bld_ovf;
  ptm_pkg::cnt_t             ev_rd;
  ptm_pkg::cnt_t             ev_size;
  logic                      ev_ovf;
  logic                      last_row;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy && (mode != ptm_pkg::MODE_NONE);
  assign is_event = (mode == ptm_pkg::MODE_EXACT) || (mode == ptm_pkg::MODE_INCL);
  assign buf_addr = busy ? col : ptm_pkg::TYPE_W'(type_code);
  assign last_row = ({1'b0, row} == total - (ptm_pkg::TOPO_W + 1)'(1));

  always_comb begin
    bld_ctl.add      = accept && (mode == ptm_pkg::MODE_TOPO);
    bld_ctl.in_range = ptm_pkg::type_in_range(type_code);
    bld_ctl.clr      = (state == S_ANSWER) && !kind_q;
    ev_ctl.add       = accept && is_event;
    ev_ctl.in_range  = ptm_pkg::type_in_range(type_code);
    ev_ctl.clr       = (state == S_ANSWER) && kind_q;
  end

  ptm_count_buf u_bld (
    .clk     (clk),
    .rst     (rst),
    .ctl     (bld_ctl),
    .addr    (buf_addr),
    .rd_data (bld_rd),
    .size    (bld_size),
    .ovf     (bld_ovf)
  );

  ptm_count_buf u_ev (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ev_ctl),
    .addr    (buf_addr),
    .rd_data (ev_rd),
    .size    (ev_size),
    .ovf     (ev_ovf)
  );

  // topology table: one count per entry, row = topology, column = type
  assign mem_we = (state == S_COPY);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{total[ptm_pkg::TOPO_W-1:0], col}] <= bld_rd;
    end
    tp_rd <= mem[{row, col}];
  end

  // shared compare unit
  always_comb begin
    if (mode_q == ptm_pkg::MODE_EXACT) begin
      step_ok = (p_ev == tp_rd);
    end else begin
      step_ok = (p_ev >= tp_rd) &&
                (!restrict_q || (int'(p_col) == int'(extra_q)) || (p_ev == tp_rd));
    end
    row_ok_next = ((p_col == '0) ? 1'b1 : row_ok) && step_ok;
  end

  always_ff @(posedge clk) begin
    p_valid <= (state == S_SCAN);
    p_row   <= row;
    p_col   <= col;
    p_ev    <= ev_rd;
    if (p_valid) begin
      row_ok <= row_ok_next;
      if ((p_col == T_LAST) && row_ok_next &&
          ((mode_q == ptm_pkg::MODE_EXACT) || !found_q)) begin
        found_q <= 1'b1;
        idx_q   <= p_row;
      end
    end

    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && last) begin
            kind_q     <= is_event;
            mode_q     <= mode;
            restrict_q <= restrict_extra;
            extra_q    <= extra_type;
            found_q    <= 1'b0;
            idx_q      <= '0;
            full_q     <= 1'b0;
            row        <= '0;
            col        <= '0;
            if (!is_event) begin
              if (int'(total) >= ptm_pkg::MAX_TOPOLOGIES) begin
                full_q <= 1'b1;
                state  <= S_ANSWER;
              end else begin
                state <= S_COPY;
              end
            end else if (total == '0) begin
              state <= S_ANSWER;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_COPY: begin
          col <= col + ptm_pkg::TYPE_W'(1);
          if (col == T_LAST) begin
            found_q <= 1'b1;
            idx_q   <= total[ptm_pkg::TOPO_W-1:0];
            state   <= S_ANSWER;
          end
        end
        S_SCAN: begin
          col <= col + ptm_pkg::TYPE_W'(1);
          if (col == T_LAST) begin
            col <= '0;
            row <= row + ptm_pkg::TOPO_W'(1);
            if (last_row) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          state <= S_ANSWER;
        end
        S_ANSWER: begin
          done           <= 1'b1;
          kind           <= kind_q;
          found          <= found_q;
          topo_index     <= found_q ? 4'(idx_q) : 4'd0;
          particle_count <= kind_q ? 5'(ev_size) : 5'(bld_size);
          if (full_q) begin
            error <= ptm_pkg::ERR_FULL;
          end else if (kind_q ? ev_ovf : bld_ovf) begin
            error <= ptm_pkg::ERR_OVF;
          end else begin
            error <= ptm_pkg::ERR_NONE;
          end
          if (!kind_q && found_q) begin
            total <= total + (ptm_pkg::TOPO_W + 1)'(1);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_ANSWER))
    else $error("result without answer step");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (total != '0))
    else $error("scan over empty table");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    int'(total) <= ptm_pkg::MAX_TOPOLOGIES)
    else $error("table total beyond capacity");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (topo_index == 4'd0))
    else $error("index on a miss");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && (error == ptm_pkg::ERR_FULL)) |-> (!found && !kind))
    else $error("full table reported as stored");

endmodule
